/* rtl/core/lse_pkg.sv */
// Shared types, opcodes and helper functions of the LEGv8 subset execute step.
package lse_pkg;

  localparam int DATA_W     = 32;
  localparam int PC_W       = 10;
  localparam int PROG_DEPTH = 1024;
  localparam int LEN_W      = 11;
  localparam int REG_COUNT  = 32;
  localparam int REG_AW     = 5;
  localparam int FLAG_W     = 14;
  localparam int TGT_W      = 27;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  localparam logic [REG_AW-1:0] LINK_REG = 5'd30;
  localparam logic [REG_AW-1:0] ZERO_REG = 5'd31;

  localparam logic [10:0] OP11_ADD  = 11'h458;
  localparam logic [10:0] OP11_SUB  = 11'h658;
  localparam logic [10:0] OP11_SUBS = 11'h758;
  localparam logic [10:0] OP11_LSL  = 11'h69B;
  localparam logic [10:0] OP11_LSR  = 11'h69A;
  localparam logic [10:0] OP11_BR   = 11'h6B0;
  localparam logic [10:0] OP11_PRNL = 11'h7FC;
  localparam logic [10:0] OP11_PRNT = 11'h7FD;
  localparam logic [10:0] OP11_DUMP = 11'h7FE;
  localparam logic [10:0] OP11_HALT = 11'h7FF;
  localparam logic [9:0]  OP10_ADDI  = 10'h244;
  localparam logic [9:0]  OP10_SUBI  = 10'h344;
  localparam logic [9:0]  OP10_SUBIS = 10'h3C4;
  localparam logic [7:0]  OP8_CBZ   = 8'hB4;
  localparam logic [7:0]  OP8_CBNZ  = 8'hB5;
  localparam logic [7:0]  OP8_BCOND = 8'h54;
  localparam logic [5:0]  OP6_B     = 6'h05;
  localparam logic [5:0]  OP6_BL    = 6'h25;

  // Condition bit positions
  localparam int F_EQ = 0;
  localparam int F_NE = 1;
  localparam int F_HS = 2;
  localparam int F_LO = 3;
  localparam int F_MI = 4;
  localparam int F_PL = 5;
  localparam int F_HI = 8;
  localparam int F_LS = 9;
  localparam int F_GE = 10;
  localparam int F_LT = 11;
  localparam int F_GT = 12;
  localparam int F_LE = 13;

  typedef enum logic [4:0] {
    OP_ADD, OP_SUB, OP_SUBS, OP_LSL, OP_LSR, OP_BR, OP_PRNT, OP_PRNL, OP_DUMP,
    OP_HALT, OP_ADDI, OP_SUBI, OP_SUBIS, OP_CBZ, OP_CBNZ, OP_BCOND, OP_B, OP_BL,
    OP_BAD
  } op_t;

  typedef enum logic [1:0] {
    PK_NONE    = 2'd0,
    PK_REG     = 2'd1,
    PK_NEWLINE = 2'd2,
    PK_DUMP    = 2'd3
  } print_kind_t;

  typedef struct packed {
    logic [PC_W-1:0]   next_pc;
    logic              halted;
    print_kind_t       kind;
    logic [REG_AW-1:0] preg;
    logic [31:0]       pval;
  } result_t;

  // Widest opcode first, then narrower ones
  function automatic op_t decode_op(input logic [31:0] w);
    op_t op;
    op = OP_BAD;
    unique case (w[31:21])
      OP11_ADD:  op = OP_ADD;
      OP11_SUB:  op = OP_SUB;
      OP11_SUBS: op = OP_SUBS;
      OP11_LSL:  op = OP_LSL;
      OP11_LSR:  op = OP_LSR;
      OP11_BR:   op = OP_BR;
      OP11_PRNL: op = OP_PRNL;
      OP11_PRNT: op = OP_PRNT;
      OP11_DUMP: op = OP_DUMP;
      OP11_HALT: op = OP_HALT;
      default: begin
        unique case (w[31:22])
          OP10_ADDI:  op = OP_ADDI;
          OP10_SUBI:  op = OP_SUBI;
          OP10_SUBIS: op = OP_SUBIS;
          default: begin
            unique case (w[31:24])
              OP8_CBZ:   op = OP_CBZ;
              OP8_CBNZ:  op = OP_CBNZ;
              OP8_BCOND: op = OP_BCOND;
              default: begin
                unique case (w[31:26])
                  OP6_B:   op = OP_B;
                  OP6_BL:  op = OP_BL;
                  default: op = OP_BAD;
                endcase
              end
            endcase
          end
        endcase
      end
    endcase
    return op;
  endfunction

  // Clear every condition bit, then set from the signed result
  function automatic logic [FLAG_W-1:0] flags_from(input logic [DATA_W-1:0] r);
    logic [FLAG_W-1:0] f;
    logic              neg;
    logic              zero;
    neg  = r[DATA_W-1];
    zero = (r == '0);
    f = '0;
    f[F_EQ] = zero;
    f[F_NE] = !zero;
    f[F_HS] = !neg;
    f[F_PL] = !neg;
    f[F_GE] = !neg;
    f[F_LO] = neg;
    f[F_MI] = neg;
    f[F_LT] = neg;
    f[F_HI] = !neg && !zero;
    f[F_GT] = !neg && !zero;
    f[F_LS] = neg || zero;
    f[F_LE] = neg || zero;
    return f;
  endfunction

endpackage

/* rtl/core/lse_ram.sv */
// Generic RAM: one write port, two registered read ports, old data on collision.
module lse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

/* rtl/core/legv8_subset_execute_step.sv */
// LEGv8 subset execute step: register-file RAM, execute stage and result queue.
// Throughput: one item per cycle while the result queue has room; the register-file read
// overlaps the previous item's execute, with write-back forwarding; a four-entry result
// queue absorbs stalls. An item passes the RAM read, then execute, then the result queue.
// Reset clears PC, condition bits, halt and the per-register written bits (so every
// register reads zero at once), and sets program_length to 1024; no clearing pass.
module legv8_subset_execute_step (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                instr_valid,
  output logic                                instr_ready,
  input  logic [31:0]                         instruction_word,
  output logic                                result_valid,
  input  logic                                result_ready,
  output logic [lse_pkg::PC_W-1:0]            next_pc,
  output logic                                halted,
  output logic [1:0]                          print_kind,
  output logic [lse_pkg::REG_AW-1:0]          print_reg,
  output logic signed [31:0]                  print_value,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lse_pkg::LEN_W-1:0]           program_length
);

  localparam int DW = lse_pkg::DATA_W;
  localparam int AW = lse_pkg::REG_AW;
  localparam int CW = lse_pkg::FIFO_AW + 1;

  // Configuration
  logic [lse_pkg::LEN_W-1:0] prog_len;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      prog_len <= lse_pkg::LEN_W'(lse_pkg::PROG_DEPTH);
    end else if (cfg_valid && cfg_ready) begin
      prog_len <= program_length;
    end
  end

  // Input decode and register-file read
  logic          instr_acc;
  lse_pkg::op_t  in_op;
  logic [AW-1:0] in_addr_a;
  logic [AW-1:0] in_addr_b;

  assign instr_acc = instr_valid && instr_ready;
  assign in_op     = lse_pkg::decode_op(instruction_word);
  assign in_addr_b = instruction_word[20:16];

  always_comb begin
    case (in_op) inside
      lse_pkg::OP_CBZ, lse_pkg::OP_CBNZ, lse_pkg::OP_PRNT: in_addr_a = instruction_word[4:0];
      lse_pkg::OP_BR:                                      in_addr_a = lse_pkg::LINK_REG;
      default:                                             in_addr_a = instruction_word[9:5];
    endcase
  end

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [DW-1:0] wr_data;
  logic [DW-1:0] ram_a;
  logic [DW-1:0] ram_b;

  lse_ram #(
    .WIDTH(DW),
    .DEPTH(lse_pkg::REG_COUNT)
  ) u_regfile (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (wr_addr),
    .wdata   (wr_data),
    .raddr_a (in_addr_a),
    .raddr_b (in_addr_b),
    .rdata_a (ram_a),
    .rdata_b (ram_b)
  );

  // Written bits stand in for the reset value of the register file
  logic [lse_pkg::REG_COUNT-1:0] reg_written;
  logic                          written_a;
  logic                          written_b;
  logic                          fwd_we;
  logic [AW-1:0]                 fwd_addr;
  logic [DW-1:0]                 fwd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_written <= '0;
      fwd_we      <= 1'b0;
    end else begin
      if (wr_en) begin
        reg_written[wr_addr] <= 1'b1;
      end
      fwd_we <= wr_en;
    end
    written_a <= reg_written[in_addr_a];
    written_b <= reg_written[in_addr_b];
    fwd_addr  <= wr_addr;
    fwd_data  <= wr_data;
  end

  // Execute stage
  logic                exec_valid;
  logic [31:0]         ex_word;
  lse_pkg::op_t        ex_op;
  logic [AW-1:0]       ex_addr_a;
  logic [AW-1:0]       ex_addr_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      exec_valid <= 1'b0;
    end else begin
      exec_valid <= instr_acc;
    end
    if (instr_acc) begin
      ex_word   <= instruction_word;
      ex_op     <= in_op;
      ex_addr_a <= in_addr_a;
      ex_addr_b <= in_addr_b;
    end
  end

  logic [DW-1:0] opnd_a;
  logic [DW-1:0] opnd_b;

  // Take the write-back that landed with this item's read
  always_comb begin
    if (ex_addr_a == lse_pkg::ZERO_REG) begin
      opnd_a = '0;
    end else if (fwd_we && fwd_addr == ex_addr_a) begin
      opnd_a = fwd_data;
    end else begin
      opnd_a = written_a ? ram_a : '0;
    end
    if (ex_addr_b == lse_pkg::ZERO_REG) begin
      opnd_b = '0;
    end else if (fwd_we && fwd_addr == ex_addr_b) begin
      opnd_b = fwd_data;
    end else begin
      opnd_b = written_b ? ram_b : '0;
    end
  end

  logic [lse_pkg::PC_W-1:0]   pc;
  logic [lse_pkg::PC_W-1:0]   pc_next;
  logic [lse_pkg::FLAG_W-1:0] cond_flags;
  logic [lse_pkg::FLAG_W-1:0] cond_flags_next;
  logic                       halt_flag;
  logic                       halt_flag_next;

  logic [lse_pkg::LEN_W-1:0]  len_eff;
  logic                       out_of_prog;
  logic [AW-1:0]              ex_rd;
  logic [5:0]                 shamt;
  logic [DW-1:0]              imm;
  logic [lse_pkg::TGT_W-1:0]  pc_ext;
  logic [lse_pkg::TGT_W-1:0]  off26;
  logic [lse_pkg::TGT_W-1:0]  off19;
  logic [lse_pkg::TGT_W-1:0]  target;
  logic [15:0]                flags_wide;
  logic                       stop;
  logic                       direct;
  logic                       wr_req;
  logic [DW-1:0]              diff;
  lse_pkg::result_t           res_in;

  assign len_eff = (prog_len > lse_pkg::LEN_W'(lse_pkg::PROG_DEPTH))
                   ? lse_pkg::LEN_W'(lse_pkg::PROG_DEPTH) : prog_len;
  assign out_of_prog = {1'b0, pc} >= len_eff;
  assign ex_rd       = ex_word[4:0];
  assign shamt       = ex_word[15:10];
  assign imm         = DW'(ex_word[21:10]);
  assign pc_ext      = lse_pkg::TGT_W'(pc);
  assign off26       = {ex_word[25], ex_word[25:0]};
  assign off19       = {{(lse_pkg::TGT_W - 19){ex_word[23]}}, ex_word[23:5]};
  assign flags_wide  = 16'(cond_flags);

  always_comb begin
    stop            = 1'b0;
    direct          = 1'b0;
    wr_req          = 1'b0;
    wr_addr         = ex_rd;
    wr_data         = '0;
    diff            = '0;
    cond_flags_next = cond_flags;
    target          = pc_ext + lse_pkg::TGT_W'(1);
    res_in.kind     = lse_pkg::PK_NONE;
    res_in.preg     = '0;
    res_in.pval     = '0;
    if (exec_valid && !halt_flag && !out_of_prog) begin
      unique case (ex_op)
        lse_pkg::OP_ADD: begin
          wr_req  = 1'b1;
          wr_data = opnd_a + opnd_b;
        end
        lse_pkg::OP_SUB: begin
          wr_req  = 1'b1;
          wr_data = opnd_a - opnd_b;
        end
        lse_pkg::OP_SUBS: begin
          diff            = opnd_a - opnd_b;
          wr_req          = 1'b1;
          wr_data         = diff;
          cond_flags_next = lse_pkg::flags_from(diff);
        end
        lse_pkg::OP_LSL: begin
          wr_req  = 1'b1;
          wr_data = (shamt >= 6'(DW)) ? '0 : opnd_a << shamt[4:0];
        end
        lse_pkg::OP_LSR: begin
          wr_req  = 1'b1;
          wr_data = (shamt >= 6'(DW)) ? '0 : opnd_a >> shamt[4:0];
        end
        lse_pkg::OP_BR: direct = 1'b1;
        lse_pkg::OP_PRNT: begin
          res_in.kind = lse_pkg::PK_REG;
          res_in.preg = ex_rd;
          res_in.pval = opnd_a[31:0];
        end
        lse_pkg::OP_PRNL: res_in.kind = lse_pkg::PK_NEWLINE;
        lse_pkg::OP_DUMP: res_in.kind = lse_pkg::PK_DUMP;
        lse_pkg::OP_HALT: begin
          res_in.kind = lse_pkg::PK_DUMP;
          stop        = 1'b1;
        end
        lse_pkg::OP_ADDI: begin
          wr_req  = 1'b1;
          wr_data = opnd_a + imm;
        end
        lse_pkg::OP_SUBI: begin
          wr_req  = 1'b1;
          wr_data = opnd_a - imm;
        end
        lse_pkg::OP_SUBIS: begin
          diff            = opnd_a - imm;
          wr_req          = 1'b1;
          wr_data         = diff;
          cond_flags_next = lse_pkg::flags_from(diff);
        end
        lse_pkg::OP_CBZ: begin
          if (opnd_a == '0) begin
            target = pc_ext + off19;
          end
        end
        lse_pkg::OP_CBNZ: begin
          if (opnd_a != '0) begin
            target = pc_ext + off19;
          end
        end
        lse_pkg::OP_BCOND: begin
          // Codes fourteen and up are never taken
          if (!ex_rd[4] && ex_rd[3:0] < 4'(lse_pkg::FLAG_W) && flags_wide[ex_rd[3:0]]) begin
            target = pc_ext + off19;
          end
        end
        lse_pkg::OP_B: target = pc_ext + off26;
        lse_pkg::OP_BL: begin
          wr_req  = 1'b1;
          wr_addr = lse_pkg::LINK_REG;
          wr_data = DW'(pc) + DW'(1);
          target  = pc_ext + off26;
        end
        default: stop = 1'b1;
      endcase
    end
    wr_en = wr_req && (wr_addr != lse_pkg::ZERO_REG);
    pc_next        = pc;
    halt_flag_next = halt_flag;
    if (exec_valid && !halt_flag) begin
      if (out_of_prog || stop) begin
        halt_flag_next = 1'b1;
      end else if (direct) begin
        if (opnd_a < DW'(len_eff)) begin
          pc_next = opnd_a[lse_pkg::PC_W-1:0];
        end else begin
          halt_flag_next = 1'b1;
        end
      end else if (!target[lse_pkg::TGT_W-1] && target < lse_pkg::TGT_W'(len_eff)) begin
        pc_next = target[lse_pkg::PC_W-1:0];
      end else begin
        halt_flag_next = 1'b1;
      end
    end
    res_in.next_pc = pc_next;
    res_in.halted  = halt_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc         <= '0;
      cond_flags <= '0;
      halt_flag  <= 1'b0;
    end else begin
      pc         <= pc_next;
      cond_flags <= cond_flags_next;
      halt_flag  <= halt_flag_next;
    end
  end

  // Result queue
  lse_pkg::result_t           res_mem [lse_pkg::FIFO_DEPTH];
  logic [lse_pkg::FIFO_AW-1:0] res_wr_ptr;
  logic [lse_pkg::FIFO_AW-1:0] res_rd_ptr;
  logic [CW-1:0]               res_count;
  logic                        res_pop;
  lse_pkg::result_t            res_out;

  assign res_pop      = result_valid && result_ready;
  assign result_valid = res_count != '0;
  // Leave room for the item already in execute
  assign instr_ready  = (res_count + CW'(exec_valid)) < CW'(lse_pkg::FIFO_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_wr_ptr <= '0;
      res_rd_ptr <= '0;
      res_count  <= '0;
    end else begin
      if (exec_valid) begin
        res_wr_ptr <= res_wr_ptr + lse_pkg::FIFO_AW'(1);
      end
      if (res_pop) begin
        res_rd_ptr <= res_rd_ptr + lse_pkg::FIFO_AW'(1);
      end
      res_count <= res_count + CW'(exec_valid) - CW'(res_pop);
    end
    if (exec_valid) begin
      res_mem[res_wr_ptr] <= res_in;
    end
  end

  assign res_out     = res_mem[res_rd_ptr];
  assign next_pc     = res_out.next_pc;
  assign halted      = res_out.halted;
  assign print_kind  = 2'(res_out.kind);
  assign print_reg   = res_out.preg;
  assign print_value = res_out.pval;

`ifndef SYNTH
  assert property (@(posedge clk) disable iff (rst) halt_flag |=> halt_flag)
    else $error("halt flag dropped without reset");
  assert property (@(posedge clk) disable iff (rst) halt_flag |=> $stable(pc))
    else $error("program counter moved while halted");
  assert property (@(posedge clk) disable iff (rst)
    res_count <= CW'(lse_pkg::FIFO_DEPTH))
    else $error("result queue overflow");
  assert property (@(posedge clk) disable iff (rst) exec_valid |-> $past(instr_acc))
    else $error("execute stage holds an item that was never accepted");
  assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (exec_valid && wr_addr != lse_pkg::ZERO_REG))
    else $error("register write outside execute or to the zero register");
`endif

endmodule

/* test/testbench.sv */
// Self-checking testbench for the LEGv8 subset execute step, with a scoreboard class.
module testbench;

  // Expected results of accepted instruction words, worked out from a model of the core state
  class step_scoreboard;
    logic [lse_pkg::DATA_W-1:0] regs [lse_pkg::REG_COUNT];
    logic [lse_pkg::PC_W-1:0]   pc;
    logic [lse_pkg::FLAG_W-1:0] flags;
    bit                         halt;
    logic [lse_pkg::LEN_W-1:0]  length;
    lse_pkg::result_t           steps_due [$];
    int                         errors;

    function new();
      foreach (regs[i]) regs[i] = '0;
      pc     = '0;
      flags  = '0;
      halt   = 1'b0;
      length = lse_pkg::LEN_W'(lse_pkg::PROG_DEPTH);
      errors = 0;
    endfunction

    function int unsigned eff_length();
      return (length > lse_pkg::PROG_DEPTH) ? lse_pkg::PROG_DEPTH : length;
    endfunction

    function logic [lse_pkg::DATA_W-1:0] read_reg(logic [lse_pkg::REG_AW-1:0] n);
      return (n == lse_pkg::ZERO_REG) ? '0 : regs[n];
    endfunction

    function void write_reg(logic [lse_pkg::REG_AW-1:0] n, logic [lse_pkg::DATA_W-1:0] v);
      if (n != lse_pkg::ZERO_REG) regs[n] = v;
    endfunction

    function void set_conditions(logic [lse_pkg::DATA_W-1:0] r);
      logic neg;
      logic zero;
      neg  = r[lse_pkg::DATA_W-1];
      zero = (r == '0);
      flags = '0;
      flags[lse_pkg::F_EQ] = zero;
      flags[lse_pkg::F_NE] = !zero;
      flags[lse_pkg::F_HS] = !neg;
      flags[lse_pkg::F_PL] = !neg;
      flags[lse_pkg::F_GE] = !neg;
      flags[lse_pkg::F_LO] = neg;
      flags[lse_pkg::F_MI] = neg;
      flags[lse_pkg::F_LT] = neg;
      flags[lse_pkg::F_HI] = !neg && !zero;
      flags[lse_pkg::F_GT] = !neg && !zero;
      flags[lse_pkg::F_LS] = neg || zero;
      flags[lse_pkg::F_LE] = neg || zero;
    endfunction

    function lse_pkg::op_t classify(logic [31:0] w);
      if (w[31:21] == lse_pkg::OP11_ADD)   return lse_pkg::OP_ADD;
      if (w[31:21] == lse_pkg::OP11_SUB)   return lse_pkg::OP_SUB;
      if (w[31:21] == lse_pkg::OP11_SUBS)  return lse_pkg::OP_SUBS;
      if (w[31:21] == lse_pkg::OP11_LSL)   return lse_pkg::OP_LSL;
      if (w[31:21] == lse_pkg::OP11_LSR)   return lse_pkg::OP_LSR;
      if (w[31:21] == lse_pkg::OP11_BR)    return lse_pkg::OP_BR;
      if (w[31:21] == lse_pkg::OP11_PRNT)  return lse_pkg::OP_PRNT;
      if (w[31:21] == lse_pkg::OP11_PRNL)  return lse_pkg::OP_PRNL;
      if (w[31:21] == lse_pkg::OP11_DUMP)  return lse_pkg::OP_DUMP;
      if (w[31:21] == lse_pkg::OP11_HALT)  return lse_pkg::OP_HALT;
      if (w[31:22] == lse_pkg::OP10_ADDI)  return lse_pkg::OP_ADDI;
      if (w[31:22] == lse_pkg::OP10_SUBI)  return lse_pkg::OP_SUBI;
      if (w[31:22] == lse_pkg::OP10_SUBIS) return lse_pkg::OP_SUBIS;
      if (w[31:24] == lse_pkg::OP8_CBZ)    return lse_pkg::OP_CBZ;
      if (w[31:24] == lse_pkg::OP8_CBNZ)   return lse_pkg::OP_CBNZ;
      if (w[31:24] == lse_pkg::OP8_BCOND)  return lse_pkg::OP_BCOND;
      if (w[31:26] == lse_pkg::OP6_B)      return lse_pkg::OP_B;
      if (w[31:26] == lse_pkg::OP6_BL)     return lse_pkg::OP_BL;
      return lse_pkg::OP_BAD;
    endfunction

    function lse_pkg::result_t execute(logic [31:0] w);
      lse_pkg::op_t               op;
      logic [lse_pkg::REG_AW-1:0] rd;
      logic [lse_pkg::REG_AW-1:0] rn;
      logic [lse_pkg::REG_AW-1:0] rm;
      logic [5:0]                 shamt;
      logic [11:0]                imm;
      logic [lse_pkg::DATA_W-1:0] r;
      logic [lse_pkg::DATA_W-1:0] abs_t;
      int                         off26;
      int                         off19;
      int                         tgt;
      int unsigned                len;
      bit                         direct;
      bit                         stop;
      lse_pkg::result_t           res;
      op     = classify(w);
      rd     = w[4:0];
      rn     = w[9:5];
      rm     = w[20:16];
      shamt  = w[15:10];
      imm    = w[21:10];
      off26  = $signed(w[25:0]);
      off19  = $signed(w[23:5]);
      len    = eff_length();
      tgt    = int'(pc) + 1;
      abs_t  = '0;
      direct = 1'b0;
      stop   = 1'b0;
      res.kind = lse_pkg::PK_NONE;
      res.preg = '0;
      res.pval = '0;
      if (!halt && pc >= len) halt = 1'b1;
      if (!halt) begin
        case (op)
          lse_pkg::OP_ADD:  write_reg(rd, read_reg(rn) + read_reg(rm));
          lse_pkg::OP_SUB:  write_reg(rd, read_reg(rn) - read_reg(rm));
          lse_pkg::OP_SUBS: begin
            r = read_reg(rn) - read_reg(rm);
            write_reg(rd, r);
            set_conditions(r);
          end
          lse_pkg::OP_LSL:
            write_reg(rd, (shamt >= lse_pkg::DATA_W) ? '0 : read_reg(rn) << shamt);
          lse_pkg::OP_LSR:
            write_reg(rd, (shamt >= lse_pkg::DATA_W) ? '0 : read_reg(rn) >> shamt);
          lse_pkg::OP_BR: begin
            direct = 1'b1;
            abs_t  = read_reg(lse_pkg::LINK_REG);
          end
          lse_pkg::OP_PRNT: begin
            res.kind = lse_pkg::PK_REG;
            res.preg = rd;
            res.pval = read_reg(rd);
          end
          lse_pkg::OP_PRNL: res.kind = lse_pkg::PK_NEWLINE;
          lse_pkg::OP_DUMP: res.kind = lse_pkg::PK_DUMP;
          lse_pkg::OP_HALT: begin
            res.kind = lse_pkg::PK_DUMP;
            stop = 1'b1;
          end
          lse_pkg::OP_ADDI: write_reg(rd, read_reg(rn) + lse_pkg::DATA_W'(imm));
          lse_pkg::OP_SUBI: write_reg(rd, read_reg(rn) - lse_pkg::DATA_W'(imm));
          lse_pkg::OP_SUBIS: begin
            r = read_reg(rn) - lse_pkg::DATA_W'(imm);
            write_reg(rd, r);
            set_conditions(r);
          end
          lse_pkg::OP_CBZ:  if (read_reg(rd) == '0) tgt = int'(pc) + off19;
          lse_pkg::OP_CBNZ: if (read_reg(rd) != '0) tgt = int'(pc) + off19;
          // codes past the last condition bit are never taken
          lse_pkg::OP_BCOND: if (rd < lse_pkg::FLAG_W && flags[rd]) tgt = int'(pc) + off19;
          lse_pkg::OP_B:    tgt = int'(pc) + off26;
          lse_pkg::OP_BL: begin
            write_reg(lse_pkg::LINK_REG, lse_pkg::DATA_W'(pc) + 1);
            tgt = int'(pc) + off26;
          end
          default:  stop = 1'b1;
        endcase
        if (stop) begin
          halt = 1'b1;
        end else if (direct) begin
          if (abs_t < len) pc = lse_pkg::PC_W'(abs_t);
          else halt = 1'b1;
        end else if (tgt >= 0 && tgt < int'(len)) begin
          pc = lse_pkg::PC_W'(tgt);
        end else begin
          halt = 1'b1;
        end
      end
      res.next_pc = pc;
      res.halted  = halt;
      return res;
    endfunction

    function void note_instruction(logic [31:0] w);
      steps_due.push_back(execute(w));
    endfunction

    function void check_step(lse_pkg::result_t got);
      lse_pkg::result_t want;
      if (steps_due.size() == 0) begin
        $display("%0t: result with no item outstanding, next_pc %0d", $time, got.next_pc);
        errors++;
        return;
      end
      want = steps_due.pop_front();
      if (got.next_pc !== want.next_pc) begin
        $display("%0t: next_pc expected %0d actual %0d", $time, want.next_pc, got.next_pc);
        errors++;
      end
      if (got.halted !== want.halted) begin
        $display("%0t: halted expected %0d actual %0d", $time, want.halted, got.halted);
        errors++;
      end
      if (got.kind !== want.kind) begin
        $display("%0t: print_kind expected %0d actual %0d", $time, want.kind, got.kind);
        errors++;
      end
      if (got.preg !== want.preg) begin
        $display("%0t: print_reg expected %0d actual %0d", $time, want.preg, got.preg);
        errors++;
      end
      if (got.pval !== want.pval) begin
        $display("%0t: print_value expected %h actual %h", $time, want.pval, got.pval);
        errors++;
      end
    endfunction

    function int pending();
      return steps_due.size();
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       instr_valid = 1'b0;
  logic                       instr_ready;
  logic [31:0]                instruction_word = '0;
  logic                       result_valid;
  logic                       result_ready = 1'b0;
  logic [lse_pkg::PC_W-1:0]   next_pc;
  logic                       halted;
  logic [1:0]                 print_kind;
  logic [lse_pkg::REG_AW-1:0] print_reg;
  logic signed [31:0]         print_value;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [lse_pkg::LEN_W-1:0]  cfg_length = '0;

  step_scoreboard sb;
  bit             quiet = 1'b0;
  int             stall_left = 0;

  legv8_subset_execute_step i_dut (
    .clk              (clk),
    .rst              (rst),
    .instr_valid      (instr_valid),
    .instr_ready      (instr_ready),
    .instruction_word (instruction_word),
    .result_valid     (result_valid),
    .result_ready     (result_ready),
    .next_pc          (next_pc),
    .halted           (halted),
    .print_kind       (print_kind),
    .print_reg        (print_reg),
    .print_value      (print_value),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .program_length   (cfg_length)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("testbench failed");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [lse_pkg::REG_AW-1:0] pick_reg();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return lse_pkg::ZERO_REG;
    if (r == 1) return lse_pkg::LINK_REG;
    return lse_pkg::REG_AW'($urandom_range(0, 31));
  endfunction

  function automatic logic [31:0] r_word(logic [10:0] op, logic [4:0] rm, logic [5:0] sh,
                                         logic [4:0] rn, logic [4:0] rd);
    return {op, rm, sh, rn, rd};
  endfunction

  function automatic logic [31:0] i_word(logic [9:0] op, logic [11:0] imm, logic [4:0] rn,
                                         logic [4:0] rd);
    return {op, imm, rn, rd};
  endfunction

  function automatic logic [31:0] cb_word(logic [7:0] op, int off, logic [4:0] rt);
    return {op, off[18:0], rt};
  endfunction

  function automatic logic [31:0] b_word(logic [5:0] op, int off);
    return {op, off[25:0]};
  endfunction

  function automatic logic [31:0] prnt_word(logic [4:0] rd);
    return {lse_pkg::OP11_PRNT, 16'($urandom), rd};
  endfunction

  function automatic logic [31:0] tail_word(logic [10:0] op);
    return {op, 21'($urandom)};
  endfunction

  // Pick an instruction that keeps the program counter inside the program
  function automatic logic [31:0] safe_word();
    int unsigned                len;
    int                         p;
    int                         off;
    int                         c;
    logic [lse_pkg::REG_AW-1:0] rd;
    logic [lse_pkg::REG_AW-1:0] rn;
    logic [lse_pkg::REG_AW-1:0] rm;
    len = sb.eff_length();
    p   = int'(sb.pc);
    off = int'($urandom_range(0, len - 1)) - p;
    rd  = pick_reg();
    rn  = pick_reg();
    rm  = ($urandom_range(0, 3) == 0) ? rn : pick_reg();
    if (p + 1 < int'(len)) begin
      case ($urandom_range(0, 19))
        0, 1:   return r_word(lse_pkg::OP11_ADD, rm, 6'($urandom), rn, rd);
        2, 3:   return r_word(lse_pkg::OP11_SUB, rm, 6'($urandom), rn, rd);
        4, 5:   return r_word(lse_pkg::OP11_SUBS, rm, 6'($urandom), rn, rd);
        6:      return r_word(lse_pkg::OP11_LSL, rm, 6'($urandom), rn, rd);
        7:      return r_word(lse_pkg::OP11_LSR, rm, 6'($urandom), rn, rd);
        8, 9:   return i_word(lse_pkg::OP10_ADDI, 12'($urandom), rn, rd);
        10:     return i_word(lse_pkg::OP10_SUBI, 12'($urandom), rn, rd);
        11, 12: return i_word(lse_pkg::OP10_SUBIS, 12'($urandom), rn, rd);
        13:     return cb_word(lse_pkg::OP8_CBZ, off, rd);
        14:     return cb_word(lse_pkg::OP8_CBNZ, off, rd);
        15, 16: begin
          c = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 31) : $urandom_range(0, 13);
          return cb_word(lse_pkg::OP8_BCOND, off, lse_pkg::REG_AW'(c));
        end
        17:     return b_word($urandom_range(0, 1) ? lse_pkg::OP6_BL : lse_pkg::OP6_B, off);
        18: begin
          if (sb.read_reg(lse_pkg::LINK_REG) < len) return tail_word(lse_pkg::OP11_BR);
          return prnt_word(rd);
        end
        default: begin
          c = $urandom_range(0, 2);
          if (c == 0) return prnt_word(rd);
          if (c == 1) return tail_word(lse_pkg::OP11_PRNL);
          return tail_word(lse_pkg::OP11_DUMP);
        end
      endcase
    end
    // last word of the program: only a taken branch stays inside
    case ($urandom_range(0, 4))
      0:       return b_word(lse_pkg::OP6_B, off);
      1:       return b_word(lse_pkg::OP6_BL, off);
      2: begin
        if (sb.read_reg(lse_pkg::LINK_REG) < len) return tail_word(lse_pkg::OP11_BR);
        return b_word(lse_pkg::OP6_B, off);
      end
      3: begin
        if (sb.read_reg(rd) == '0) return cb_word(lse_pkg::OP8_CBZ, off, rd);
        return cb_word(lse_pkg::OP8_CBNZ, off, rd);
      end
      default: begin
        c = $urandom_range(0, lse_pkg::FLAG_W - 1);
        if (sb.flags[c]) return cb_word(lse_pkg::OP8_BCOND, off, lse_pkg::REG_AW'(c));
        return b_word(lse_pkg::OP6_B, off);
      end
    endcase
  endfunction

  task automatic send(logic [31:0] w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      instr_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    instr_valid      <= 1'b1;
    instruction_word <= w;
    do @(posedge clk); while (!instr_ready);
    sb.note_instruction(w);
  endtask

  // Hold off the sender until every outstanding result has been seen
  task automatic wait_drained();
    instr_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_length(logic [lse_pkg::LEN_W-1:0] v);
    wait_drained();
    cfg_length <= v;
    cfg_valid  <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.length = v;
  endtask

  task automatic set_length(logic [lse_pkg::LEN_W-1:0] v);
    if (sb.pc >= v) send(b_word(lse_pkg::OP6_B, -int'(sb.pc)));
    write_length(v);
  endtask

  task automatic run_random(int count);
    repeat (count) begin
      if ($urandom_range(0, 59) == 0) wait_drained();
      send(safe_word());
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        sb.check_step(lse_pkg::result_t'{next_pc, halted,
                                         lse_pkg::print_kind_t'(print_kind), print_reg,
                                         print_value});
      end
      if (stall_left > 0) begin
        stall_left--;
        result_ready <= 1'b0;
      end else begin
        stall_left = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
        result_ready <= (stall_left == 0);
      end
    end
  end

  initial begin
    logic [31:0] w;
    int          t;
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send(i_word(lse_pkg::OP10_ADDI, 12'hFFF, lse_pkg::ZERO_REG, 5'd1));
    send(i_word(lse_pkg::OP10_ADDI, 12'h000, lse_pkg::ZERO_REG, 5'd2));
    send(i_word(lse_pkg::OP10_SUBI, 12'h001, lse_pkg::ZERO_REG, 5'd3));
    send(r_word(lse_pkg::OP11_ADD, 5'd1, 6'd63, 5'd3, 5'd4));
    send(r_word(lse_pkg::OP11_SUB, 5'd3, 6'd0, 5'd2, 5'd5));
    send(r_word(lse_pkg::OP11_SUBS, 5'd1, 6'd0, 5'd1, 5'd6));
    send(cb_word(lse_pkg::OP8_BCOND, 2, lse_pkg::REG_AW'(lse_pkg::F_EQ)));
    send(i_word(lse_pkg::OP10_SUBIS, 12'h001, lse_pkg::ZERO_REG, 5'd7));
    send(cb_word(lse_pkg::OP8_BCOND, 2, 5'd20));
    send(cb_word(lse_pkg::OP8_BCOND, 3, lse_pkg::REG_AW'(lse_pkg::F_LT)));
    send(r_word(lse_pkg::OP11_LSL, 5'd0, 6'd31, 5'd3, 5'd8));
    send(r_word(lse_pkg::OP11_LSL, 5'd0, 6'd40, 5'd3, 5'd9));
    send(r_word(lse_pkg::OP11_LSR, 5'd0, 6'd1, 5'd3, 5'd10));
    send(r_word(lse_pkg::OP11_LSR, 5'd0, 6'd63, 5'd3, 5'd11));
    send(i_word(lse_pkg::OP10_ADDI, 12'h005, 5'd1, lse_pkg::ZERO_REG));
    send(prnt_word(lse_pkg::ZERO_REG));
    send(prnt_word(5'd8));
    send({lse_pkg::OP11_PRNL, 21'h1FFFFF});
    send({lse_pkg::OP11_DUMP, 21'h000000});
    send(cb_word(lse_pkg::OP8_CBZ, 2, 5'd2));
    send(cb_word(lse_pkg::OP8_CBNZ, -3, 5'd1));
    send(cb_word(lse_pkg::OP8_CBZ, 7, 5'd1));
    send(b_word(lse_pkg::OP6_BL, 10));
    send(tail_word(lse_pkg::OP11_BR));
    send(i_word(lse_pkg::OP10_SUBIS, 12'hFFF, 5'd1, 5'd12));
    send(b_word(lse_pkg::OP6_B, -int'(sb.pc)));

    run_random(150);
    quiet = 1'b1;
    set_length(11'd2047);
    run_random(80);
    quiet = 1'b0;
    set_length(11'd1);
    run_random(25);
    set_length(11'd2);
    run_random(30);
    set_length(lse_pkg::LEN_W'($urandom_range(3, 40)));
    run_random(60);
    set_length(lse_pkg::LEN_W'($urandom_range(41, 2047)));
    run_random(60);
    set_length(lse_pkg::LEN_W'(lse_pkg::PROG_DEPTH));
    run_random(190);

    // Halting is permanent, so exactly one way of stopping closes the run
    send(b_word(lse_pkg::OP6_B, -int'(sb.pc)));
    case ($urandom_range(0, 5))
      0: send(tail_word(lse_pkg::OP11_HALT));
      1: begin
        do w = $urandom; while (sb.classify(w) != lse_pkg::OP_BAD);
        send(w);
      end
      2: begin
        if ($urandom_range(0, 1)) t = -(int'(sb.pc) + 1 + $urandom_range(0, 1000));
        else t = int'(sb.eff_length()) - int'(sb.pc) + $urandom_range(0, 1000);
        if ($urandom_range(0, 1)) begin
          send(b_word($urandom_range(0, 1) ? lse_pkg::OP6_BL : lse_pkg::OP6_B, t));
        end else begin
          send(cb_word(lse_pkg::OP8_CBZ, t, lse_pkg::ZERO_REG));
        end
      end
      3: begin
        send(i_word(lse_pkg::OP10_ADDI, 12'($urandom_range(lse_pkg::PROG_DEPTH, 4095)),
                    lse_pkg::ZERO_REG, lse_pkg::LINK_REG));
        send(tail_word(lse_pkg::OP11_BR));
      end
      4: begin
        t = $urandom_range(1, lse_pkg::PROG_DEPTH - 1);
        send(b_word(lse_pkg::OP6_B, t - int'(sb.pc)));
        write_length(lse_pkg::LEN_W'($urandom_range(0, t)));
        send(prnt_word(pick_reg()));
      end
      default: begin
        write_length('0);
        send(safe_word());
      end
    endcase
    repeat (12) send($urandom);
    send(prnt_word(5'd3));

    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
